@@ rtl/core/csma_ca_backoff_controller_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef CSMA_CA_BACKOFF_CONTROLLER_DEFINES_SVH
`define CSMA_CA_BACKOFF_CONTROLLER_DEFINES_SVH

// Checked on every edge, reset included.
`define CSMA_BO_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("csma_bo: assertion failed");

// Checked only while reset is low.
`define CSMA_BO_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("csma_bo: assertion failed");

`endif

@@ rtl/core/csma_bo_pkg.sv @@
package csma_bo_pkg;

   // Field widths.
   localparam int unsigned EXP_W    = 4;
   localparam int unsigned RETRY_W  = 3;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned DELAY_W  = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 4;

   // Default number of timer ticks in one backoff period.
   localparam int unsigned UNIT_TICKS_DEFAULT = 20;

   // Register reset values.
   localparam logic [EXP_W-1:0]   MIN_BE_RESET      = 4'd3;
   localparam logic [EXP_W-1:0]   MAX_BE_RESET      = 4'd5;
   localparam logic [RETRY_W-1:0] MAX_RETRIES_RESET = 3'd4;

   // Radio status codes.
   localparam logic [STATUS_W-1:0] STATUS_SUCCESS = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BUSY    = 3'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_BE      = 2'd0,
      CSR_MAX_BE      = 2'd1,
      CSR_MAX_RETRIES = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_SEND    = 2'd0,
      OP_TIMER   = 2'd1,
      OP_TX_DONE = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_REJECT  = 3'd1,
      ACT_BACKOFF = 3'd2,
      ACT_TX      = 3'd3,
      ACT_DONE    = 3'd4,
      ACT_READY   = 3'd5
   } action_type;

   typedef struct packed {
      op_type              op;
      logic                timer_free;
      logic [BYTE_W-1:0]   exp_offset;
      logic [BYTE_W-1:0]   prior_backoffs;
      logic [STATUS_W-1:0] lower_status;
      logic [BYTE_W-1:0]   random_bits;
   } item_type;

   typedef struct packed {
      action_type          action;
      logic [DELAY_W-1:0]  delay_ticks;
      logic [STATUS_W-1:0] done_status;
      logic [BYTE_W-1:0]   total_backoffs;
   } result_type;

endpackage

@@ rtl/core/csma_bo_req_if.sv @@
interface csma_bo_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       timer_free;
   logic [7:0] exp_offset;
   logic [7:0] prior_backoffs;
   logic [2:0] lower_status;
   logic [7:0] random_bits;

   modport source (
      output valid, op, timer_free, exp_offset, prior_backoffs, lower_status, random_bits,
      input  ready
   );
   modport sink (
      input  valid, op, timer_free, exp_offset, prior_backoffs, lower_status, random_bits,
      output ready
   );
endinterface

@@ rtl/core/csma_bo_rsp_if.sv @@
interface csma_bo_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] delay_ticks;
   logic [2:0]  done_status;
   logic [7:0]  total_backoffs;

   modport source (
      output valid, action, delay_ticks, done_status, total_backoffs,
      input  ready
   );
   modport sink (
      input  valid, action, delay_ticks, done_status, total_backoffs,
      output ready
   );
endinterface

@@ rtl/core/csma_bo_engine.sv @@
module csma_bo_engine #(
   parameter int unsigned UNIT_TICKS = csma_bo_pkg::UNIT_TICKS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [csma_bo_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [csma_bo_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                      step,
   input  csma_bo_pkg::item_type                     item,
   output csma_bo_pkg::result_type                   result
);

   typedef enum logic [1:0] {
      MODE_READY   = 2'd0,
      MODE_PENDING = 2'd1,
      MODE_SENDING = 2'd2
   } mode_type;

   localparam logic [csma_bo_pkg::DELAY_W-1:0] UNIT_TICKS_W =
      csma_bo_pkg::DELAY_W'(UNIT_TICKS);

   mode_type                                mode_ff, mode_in;
   logic [csma_bo_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [csma_bo_pkg::BYTE_W-1:0]          frame_off_ff, frame_off_in;
   logic [csma_bo_pkg::BYTE_W-1:0]          frame_bo_ff, frame_bo_in;
   logic [csma_bo_pkg::EXP_W-1:0]           min_be_ff, max_be_ff;
   logic [csma_bo_pkg::RETRY_W-1:0]         max_retries_ff;

   logic                                    is_send;
   logic [csma_bo_pkg::BYTE_W-1:0]          bo_offset;
   logic [csma_bo_pkg::COUNT_W-1:0]         bo_count;
   logic [csma_bo_pkg::BYTE_W-1:0]          bo_frame;
   logic [csma_bo_pkg::BYTE_W-1:0]          exp_sum;
   logic [csma_bo_pkg::EXP_W-1:0]           exp_sel;
   logic [csma_bo_pkg::BYTE_W-1:0]          rnd_mask;
   logic [csma_bo_pkg::BYTE_W-1:0]          rnd_masked;
   logic [csma_bo_pkg::DELAY_W-1:0]         delay_calc;
   logic                                    retry_ok;
   logic                                    do_backoff;

   // A send request starts a fresh frame, so its backoff uses the new offset and a zero count.
   assign is_send   = (item.op == csma_bo_pkg::OP_SEND);
   assign bo_offset = is_send ? item.exp_offset : frame_off_ff;
   assign bo_count  = is_send ? '0 : count_ff;
   assign bo_frame  = is_send ? item.prior_backoffs : frame_bo_ff;

   // Backoff exponent, wrapped at 8 bits and clamped to the configured maximum.
   assign exp_sum = bo_offset + csma_bo_pkg::BYTE_W'(min_be_ff)
                    + csma_bo_pkg::BYTE_W'(bo_count);
   assign exp_sel = (exp_sum > csma_bo_pkg::BYTE_W'(max_be_ff)) ? max_be_ff
                    : exp_sum[csma_bo_pkg::EXP_W-1:0];

   // An exponent of eight or more keeps every random bit.
   assign rnd_mask   = (exp_sel >= 4'd8) ? '1
                       : csma_bo_pkg::BYTE_W'((9'd1 << exp_sel) - 9'd1);
   assign rnd_masked = item.random_bits & rnd_mask;
   assign delay_calc = csma_bo_pkg::DELAY_W'(csma_bo_pkg::DELAY_W'(rnd_masked) * UNIT_TICKS_W);

   // A busy radio may retry while the count has not passed the limit.
   assign retry_ok = (count_ff <= csma_bo_pkg::COUNT_W'(max_retries_ff));

   // Event decode: next state and the result of this transaction.
   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      frame_off_in = frame_off_ff;
      frame_bo_in  = frame_bo_ff;
      do_backoff   = 1'b0;
      result       = '{action: csma_bo_pkg::ACT_NONE, delay_ticks: '0,
                       done_status: '0, total_backoffs: '0};

      unique case (item.op)
         csma_bo_pkg::OP_SEND: begin
            count_in = '0;
            if (mode_ff != MODE_READY || !item.timer_free) begin
               result.action      = csma_bo_pkg::ACT_REJECT;
               result.done_status = csma_bo_pkg::STATUS_BUSY;
            end else begin
               frame_off_in = item.exp_offset;
               mode_in      = MODE_PENDING;
               do_backoff   = 1'b1;
            end
         end
         csma_bo_pkg::OP_TIMER: begin
            if (mode_ff != MODE_READY) begin
               if (item.lower_status == csma_bo_pkg::STATUS_SUCCESS) begin
                  mode_in       = MODE_SENDING;
                  result.action = csma_bo_pkg::ACT_TX;
               end else if (retry_ok) begin
                  do_backoff = 1'b1;
               end else begin
                  mode_in            = MODE_READY;
                  result.action      = csma_bo_pkg::ACT_DONE;
                  result.done_status = item.lower_status;
               end
            end
         end
         csma_bo_pkg::OP_TX_DONE: begin
            if (mode_ff == MODE_SENDING) begin
               if (item.lower_status == csma_bo_pkg::STATUS_BUSY && retry_ok) begin
                  do_backoff = 1'b1;
               end else begin
                  mode_in            = MODE_READY;
                  result.action      = csma_bo_pkg::ACT_DONE;
                  result.done_status = item.lower_status;
               end
            end
         end
         csma_bo_pkg::OP_QUERY: begin
            if (mode_ff == MODE_READY && item.timer_free) begin
               result.action = csma_bo_pkg::ACT_READY;
            end
         end
         default: begin
            result.action = csma_bo_pkg::ACT_NONE;
         end
      endcase

      // Every backoff counts once in both the attempt and the frame.
      if (do_backoff) begin
         result.action      = csma_bo_pkg::ACT_BACKOFF;
         result.delay_ticks = delay_calc;
         count_in           = bo_count + csma_bo_pkg::COUNT_W'(1);
         frame_bo_in        = bo_frame + csma_bo_pkg::BYTE_W'(1);
      end

      if (result.action == csma_bo_pkg::ACT_BACKOFF || result.action == csma_bo_pkg::ACT_TX ||
          result.action == csma_bo_pkg::ACT_DONE) begin
         result.total_backoffs = frame_bo_in;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_READY;
         count_ff       <= '0;
         frame_off_ff   <= '0;
         frame_bo_ff    <= '0;
         min_be_ff      <= csma_bo_pkg::MIN_BE_RESET;
         max_be_ff      <= csma_bo_pkg::MAX_BE_RESET;
         max_retries_ff <= csma_bo_pkg::MAX_RETRIES_RESET;
      end else begin
         if (step) begin
            mode_ff      <= mode_in;
            count_ff     <= count_in;
            frame_off_ff <= frame_off_in;
            frame_bo_ff  <= frame_bo_in;
         end
         if (csr_we) begin
            if (csr_index == csma_bo_pkg::CSR_MIN_BE) begin
               min_be_ff <= csr_wdata;
            end else if (csr_index == csma_bo_pkg::CSR_MAX_BE) begin
               max_be_ff <= csr_wdata;
            end else if (csr_index == csma_bo_pkg::CSR_MAX_RETRIES) begin
               max_retries_ff <= csr_wdata[csma_bo_pkg::RETRY_W-1:0];
            end
         end
      end
   end

endmodule

@@ rtl/core/csma_ca_backoff_controller.sv @@
// The accepting edge loads the input register; the result register is loaded from it when it
// is empty or being drained, and the result is valid from then on.
// Throughput: one transaction per cycle while results are taken; with a result stalled the
// input register still takes one more request, then the request side stalls.
// Reset: synchronous, active high; empties both registers, sets ready mode and defaults.
module csma_ca_backoff_controller #(
   parameter int unsigned UNIT_TICKS = csma_bo_pkg::UNIT_TICKS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [csma_bo_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csma_bo_pkg::CSR_DATA_W-1:0] csr_wdata,
   csma_bo_req_if.sink                        req_ch,
   csma_bo_rsp_if.source                      rsp_ch
);

   logic                    s1_valid_ff;
   csma_bo_pkg::item_type   s1_item_ff, s1_item_in;
   logic                    rsp_valid_ff;
   csma_bo_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                    advance;

   // The input stage moves on whenever the result register is empty or being drained.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   // Request payload as it is captured.
   always_comb begin
      s1_item_in.op             = csma_bo_pkg::op_type'(req_ch.op);
      s1_item_in.timer_free     = req_ch.timer_free;
      s1_item_in.exp_offset     = req_ch.exp_offset;
      s1_item_in.prior_backoffs = req_ch.prior_backoffs;
      s1_item_in.lower_status   = req_ch.lower_status;
      s1_item_in.random_bits    = req_ch.random_bits;
   end

   csma_bo_engine #(
      .UNIT_TICKS (UNIT_TICKS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .item      (s1_item_ff),
      .result    (rsp_data_in)
   );

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_item_ff <= s1_item_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.action         = rsp_data_ff.action;
   assign rsp_ch.delay_ticks    = rsp_data_ff.delay_ticks;
   assign rsp_ch.done_status    = rsp_data_ff.done_status;
   assign rsp_ch.total_backoffs = rsp_data_ff.total_backoffs;

endmodule

@@ rtl/core/csma_bo_checker.sv @@
`include "csma_ca_backoff_controller_defines.svh"

module csma_bo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_action,
   input logic [15:0] rsp_delay_ticks,
   input logic [2:0]  rsp_done_status,
   input logic [7:0]  rsp_total_backoffs
);

   logic        rsp_stall;
   logic [29:0] rsp_data;

   // A result that is offered but not taken, and the whole result payload.
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_data  = {rsp_action, rsp_delay_ticks, rsp_done_status, rsp_total_backoffs};

   // Reset empties the result register.
   `CSMA_BO_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

   // With no result waiting, the block always takes a request.
   `CSMA_BO_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // An accepted request has produced or is holding a result once it has passed the input register.
   `CSMA_BO_ASSERT(a_result_follows, clock, reset, req_valid && req_ready |=> ##1 rsp_valid)

   // A stalled result holds.
   `CSMA_BO_ASSERT(a_rsp_holds, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_data))

endmodule

bind csma_ca_backoff_controller csma_bo_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_action         (rsp_ch.action),
   .rsp_delay_ticks    (rsp_ch.delay_ticks),
   .rsp_done_status    (rsp_ch.done_status),
   .rsp_total_backoffs (rsp_ch.total_backoffs)
);
